// ===== rtl/core/ddt_pkg.sv =====
// ddt_pkg: beat types, config bundle, magic tables and crc-16 byte update
// for the datagram deframer; no dependencies
package ddt_pkg;

    localparam int unsigned CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_PAYLOAD_LIMIT = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [7:0]  LIMIT_RESET   = 8'd64;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  frame_length;
        logic [15:0] frame_crc;
        logic        last_byte;
        logic        crc_ok;
    } out_item_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  payload_limit;
    } cfg_t;

    function automatic logic [7:0] start_magic(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'hEE;
            2'd2:    v = 8'hFF;
            default: v = 8'hC0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] end_magic(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'hEF;
            2'd1:    v = 8'hBE;
            2'd2:    v = 8'hAD;
            default: v = 8'hDE;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/ddt_fsm.sv =====
// ddt_fsm: receive state machine, header capture, idle timer and payload crc
// depends on ddt_pkg
module ddt_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ddt_pkg::in_item_t item,
    input  ddt_pkg::cfg_t     cfg,
    output logic              res_valid,
    output ddt_pkg::out_item_t res_item
);
    import ddt_pkg::*;

    localparam logic [1:0] PH_HUNT      = 2'd0;
    localparam logic [1:0] PH_HEADER    = 2'd1;
    localparam logic [1:0] PH_END_MAGIC = 2'd2;
    localparam logic [1:0] PH_DATA      = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  mcnt_reg, mcnt_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  hlen_reg, hlen_next;
    logic [15:0] hcrc_reg, hcrc_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [15:0] idle_reg, idle_next;

    logic        timed_out;
    logic [1:0]  ph;
    logic [2:0]  mc;
    logic [7:0]  pos;
    logic [7:0]  pos_inc;
    logic [2:0]  mc_inc;
    logic [15:0] crc_new;
    logic        last;
    logic [7:0]  b;

    always_comb
    begin
        b          = item.rx_byte;
        timed_out  = (cfg.timeout_ticks != 16'd0) && (idle_reg >= cfg.timeout_ticks);
        ph         = timed_out ? PH_HUNT : phase_reg;
        mc         = timed_out ? 3'd0 : mcnt_reg;
        pos        = timed_out ? 8'd0 : pos_reg;
        pos_inc    = pos + 8'd1;
        mc_inc     = mc + 3'd1;
        crc_new    = crc_update(rcrc_reg, b);
        last       = (pos_inc >= hlen_reg) || (pos_inc >= cfg.payload_limit);

        phase_next = phase_reg;
        mcnt_next  = mcnt_reg;
        pos_next   = pos_reg;
        hlen_next  = hlen_reg;
        hcrc_next  = hcrc_reg;
        rcrc_next  = rcrc_reg;
        idle_next  = idle_reg;
        res_valid  = 1'b0;

        res_item.payload_byte = b;
        res_item.frame_length = hlen_reg;
        res_item.frame_crc    = hcrc_reg;
        res_item.last_byte    = last;
        res_item.crc_ok       = last && (hlen_reg != 8'd0) && (crc_new == hcrc_reg);

        if (accept)
        begin
            if (item.opcode == OP_TICK)
            begin
                if (idle_reg < cfg.timeout_ticks)
                    idle_next = idle_reg + 16'd1;
            end
            else
            begin
                idle_next  = 16'd0;
                phase_next = ph;
                mcnt_next  = mc;
                pos_next   = pos;
                case (ph)
                    PH_HEADER:
                    begin
                        if (pos == 8'd0)
                            hlen_next = b;
                        else if (pos == 8'd1)
                            hcrc_next = {hcrc_reg[15:8], b};
                        else
                            hcrc_next = {b, hcrc_reg[7:0]};
                        pos_next = pos_inc;
                        if (pos_inc >= 8'd3)
                        begin
                            pos_next   = 8'd0;
                            mcnt_next  = 3'd0;
                            phase_next = PH_END_MAGIC;
                        end
                    end
                    PH_END_MAGIC:
                    begin
                        if (b == end_magic(mc[1:0]))
                            mcnt_next = mc_inc;
                        else
                            mcnt_next = 3'd0;
                        if ((b == end_magic(mc[1:0])) && (mc_inc >= 3'd4))
                        begin
                            mcnt_next  = 3'd0;
                            pos_next   = 8'd0;
                            rcrc_next  = 16'd0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        res_valid = 1'b1;
                        rcrc_next = crc_new;
                        pos_next  = pos_inc;
                        if (last)
                        begin
                            pos_next   = 8'd0;
                            mcnt_next  = 3'd0;
                            phase_next = PH_HUNT;
                        end
                    end
                    default:
                    begin
                        if (b == start_magic(mc[1:0]))
                            mcnt_next = mc_inc;
                        else
                            mcnt_next = 3'd0;
                        if ((b == start_magic(mc[1:0])) && (mc_inc >= 3'd4))
                        begin
                            mcnt_next  = 3'd0;
                            pos_next   = 8'd0;
                            hlen_next  = 8'd0;
                            hcrc_next  = 16'd0;
                            phase_next = PH_HEADER;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            mcnt_reg  <= 3'd0;
            pos_reg   <= 8'd0;
            hlen_reg  <= 8'd0;
            hcrc_reg  <= 16'd0;
            rcrc_reg  <= 16'd0;
            idle_reg  <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            mcnt_reg  <= mcnt_next;
            pos_reg   <= pos_next;
            hlen_reg  <= hlen_next;
            hcrc_reg  <= hcrc_next;
            rcrc_reg  <= rcrc_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

// ===== rtl/core/ddt_out_stage.sv =====
// ddt_out_stage: result register holding one payload beat until taken
// depends on ddt_pkg
module ddt_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  ddt_pkg::out_item_t load_item,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output ddt_pkg::out_item_t out_item
);
    import ddt_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    always_comb
    begin
        can_load   = !valid_reg || out_ready;
        valid_next = valid_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= load_item;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/core/datagram_deframer_with_timeout.sv =====
// datagram_deframer_with_timeout: top level with config registers, receive fsm
// and result register; depends on ddt_pkg, ddt_fsm, ddt_out_stage
//
//   channel | signals                               | beat
//   in      | in_valid, in_ready, in_item           | one rx byte or one timer tick
//   out     | out_valid, out_ready, out_item        | one payload byte with header info
//   cfg     | cfg_valid, cfg_ready, cfg_index/data  | one register write
//
// one item per cycle while in_ready is high; each byte or tick is handled in the
// cycle it is taken, a payload result appears in the result register on the next cycle
// in_ready drops only while the result register is full and out_ready is low
// cfg is always ready; reset restores timeout 100 and payload limit 64
module datagram_deframer_with_timeout (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ddt_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ddt_pkg::out_item_t                 out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ddt_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [15:0]                        cfg_data
);
    import ddt_pkg::*;

    cfg_t      cfg_reg;
    logic      accept;
    logic      res_valid;
    out_item_t res_item;
    logic      can_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_load;
    assign accept    = in_valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.payload_limit <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                CFG_PAYLOAD_LIMIT: cfg_reg.payload_limit <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ddt_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (in_item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    ddt_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_item (res_item),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
